// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the checker module of the block allocator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BBA_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("bitmap allocator check failed");

// Next-cycle implication, disabled while reset is high.
`define BBA_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("bitmap allocator check failed");

`endif

// File: sv/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and codes of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int ADDR_W = 32;
  localparam int SIZE_W = 13;
  localparam int COUNT_W = 7;

  // Request codes.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BASE          = 2'd0;
  localparam logic [1:0] CFG_BLOCK_BYTES   = 2'd1;
  localparam logic [1:0] CFG_BLOCKS_IN_USE = 2'd2;

  // Configuration reset values.
  localparam logic [ADDR_W-1:0]  RST_BASE          = 32'd0;
  localparam logic [SIZE_W-1:0]  RST_BLOCK_BYTES   = 13'd256;
  localparam logic [COUNT_W-1:0] RST_BLOCKS_IN_USE = 7'd32;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_EXHAUSTED   = 2'd1,
    STATUS_NOT_POOL    = 2'd2,
    STATUS_DOUBLE_FREE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RANGE,
    ST_DIV_WAIT,
    ST_FREE_RD,
    ST_FREE_CHK
  } state_t;

  // Result of the serial divider.
  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] quotient;
    logic [SIZE_W-1:0] remainder;
  } div_res_t;

endpackage

// File: sv/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// Fixed-size block pool allocator with a one-bit-per-block used map.
//
//   Channel   Handshake            Payload
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//   request   start/busy           req_type, free_address
//   result    done (strobe)        status, block_address, block_number,
//                                  num_free, alloc_total, fallback_total
//
// An allocate scans the used map one entry per cycle through its single read
// port until it finds a clear entry or has checked the whole pool. A free
// outside the pool skips the divider; otherwise the 32-step serial divider
// finds the block, and on a block boundary its map entry is read and checked.
// A clearing pass over every entry after reset holds busy high; configuration
// writes are taken throughout. done lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int MAX_BLOCKS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [ADDR_W-1:0]  cfg_data,
  input  logic               start,
  output logic               busy,
  input  logic               req_type,
  input  logic [ADDR_W-1:0]  free_address,
  output logic               done,
  output logic [1:0]         status,
  output logic [ADDR_W-1:0]  block_address,
  output logic [5:0]         block_number,
  output logic [COUNT_W-1:0] num_free,
  output logic [ADDR_W-1:0]  alloc_total,
  output logic [ADDR_W-1:0]  fallback_total
);

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int SW = (IW + 1 > COUNT_W) ? IW + 1 : COUNT_W;
  localparam int CntCap = (MAX_BLOCKS < 127) ? MAX_BLOCKS : 127;
  localparam logic [COUNT_W-1:0] CntCapW = COUNT_W'(CntCap);
  localparam logic [SW-1:0] LastEntry = SW'(MAX_BLOCKS - 1);
  localparam int EXT_W = SIZE_W + COUNT_W;

  // Configuration registers.
  logic [ADDR_W-1:0]  base_address;
  logic [SIZE_W-1:0]  block_bytes;
  logic [COUNT_W-1:0] blocks_in_use;

  state_t             state, state_next;
  logic [SW-1:0]      scan_idx;
  logic               chk_vld;
  logic [IW-1:0]      chk_idx;
  logic [ADDR_W-1:0]  issue_addr;
  logic [ADDR_W-1:0]  chk_addr;
  logic [ADDR_W-1:0]  offset;
  logic [IW-1:0]      free_idx;
  logic [COUNT_W-1:0] used_count;
  logic [ADDR_W-1:0]  alloc_cnt;
  logic [ADDR_W-1:0]  fb_cnt;
  status_t            res_status;
  logic [ADDR_W-1:0]  res_addr;
  logic [IW-1:0]      res_num;
  logic [ADDR_W-1:0]  num_wide;

  logic [SIZE_W-1:0]  eff_size;
  logic [COUNT_W-1:0] eff_count;
  logic [EXT_W-1:0]   extent;
  logic               scan_more;
  logic               found;
  logic               in_range;
  logic               div_ok;

  logic               we;
  logic [IW-1:0]      waddr;
  logic               wdata;
  logic [IW-1:0]      raddr;
  logic               rdata;
  logic               div_start;
  div_res_t           div_res;

  // Configuration write port, always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address  <= RST_BASE;
      block_bytes   <= RST_BLOCK_BYTES;
      blocks_in_use <= RST_BLOCKS_IN_USE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BASE:          base_address  <= cfg_data;
        CFG_BLOCK_BYTES:   block_bytes   <= cfg_data[SIZE_W-1:0];
        CFG_BLOCKS_IN_USE: blocks_in_use <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective size and count, with zero and out-of-range values clamped.
  always_comb begin
    eff_size = (block_bytes == '0) ? SIZE_W'(1) : block_bytes;
    if (blocks_in_use == '0) begin
      eff_count = COUNT_W'(1);
    end else if (blocks_in_use > CntCapW) begin
      eff_count = CntCapW;
    end else begin
      eff_count = blocks_in_use;
    end
  end

  assign extent    = EXT_W'(eff_size) * EXT_W'(eff_count);
  assign scan_more = scan_idx < SW'(eff_count);
  assign found     = chk_vld && !rdata;
  assign in_range  = offset < ADDR_W'(extent);
  assign div_ok    = (div_res.remainder == '0) &&
                     (div_res.quotient < ADDR_W'(MAX_BLOCKS));

  // Used map and serial divider.
  bba_map #(
    .DEPTH (MAX_BLOCKS),
    .AW    (IW)
  ) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  bba_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (offset),
    .divisor  (eff_size),
    .res      (div_res)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state, map port and divider control.
  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = scan_idx[IW-1:0];
    wdata      = 1'b0;
    raddr      = scan_idx[IW-1:0];
    div_start  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        we = 1'b1;
        if (scan_idx == LastEntry) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = (req_type == REQ_FREE) ? ST_RANGE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (found) begin
          we         = 1'b1;
          waddr      = chk_idx;
          wdata      = 1'b1;
          state_next = ST_IDLE;
        end else if (!scan_more) begin
          state_next = ST_IDLE;
        end
      end
      ST_RANGE: begin
        if (in_range) begin
          div_start  = 1'b1;
          state_next = ST_DIV_WAIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV_WAIT: begin
        if (div_res.done) begin
          state_next = div_ok ? ST_FREE_RD : ST_IDLE;
        end
      end
      ST_FREE_RD: begin
        raddr      = free_idx;
        state_next = ST_FREE_CHK;
      end
      ST_FREE_CHK: begin
        if (rdata) begin
          we    = 1'b1;
          waddr = free_idx;
        end
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

  // Control counters and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      chk_vld    <= 1'b0;
      used_count <= '0;
      alloc_cnt  <= '0;
      fb_cnt     <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLEAR: begin
          scan_idx <= scan_idx + 1'b1;
        end
        ST_IDLE: begin
          if (start) begin
            scan_idx <= '0;
            chk_vld  <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (found) begin
            used_count <= used_count + 1'b1;
            alloc_cnt  <= alloc_cnt + 1'b1;
            done       <= 1'b1;
          end else if (scan_more) begin
            chk_vld  <= 1'b1;
            scan_idx <= scan_idx + 1'b1;
          end else begin
            alloc_cnt <= alloc_cnt + 1'b1;
            fb_cnt    <= fb_cnt + 1'b1;
            done      <= 1'b1;
          end
        end
        ST_RANGE: begin
          if (!in_range) begin
            done <= 1'b1;
          end
        end
        ST_DIV_WAIT: begin
          if (div_res.done && !div_ok) begin
            done <= 1'b1;
          end
        end
        ST_FREE_CHK: begin
          if (rdata && used_count != '0) begin
            used_count <= used_count - 1'b1;
          end
          done <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Addresses, indexes and result payload.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        issue_addr <= base_address;
        offset     <= free_address - base_address;
      end
      ST_SCAN: begin
        if (found) begin
          res_status <= STATUS_OK;
          res_addr   <= chk_addr;
          res_num    <= chk_idx;
        end else if (scan_more) begin
          chk_idx    <= scan_idx[IW-1:0];
          chk_addr   <= issue_addr;
          issue_addr <= issue_addr + ADDR_W'(eff_size);
        end else begin
          res_status <= STATUS_EXHAUSTED;
          res_addr   <= '0;
          res_num    <= '0;
        end
      end
      ST_RANGE: begin
        res_status <= STATUS_NOT_POOL;
        res_addr   <= '0;
        res_num    <= '0;
      end
      ST_DIV_WAIT: begin
        if (div_res.done) begin
          free_idx <= div_res.quotient[IW-1:0];
        end
      end
      ST_FREE_CHK: begin
        res_status <= rdata ? STATUS_OK : STATUS_DOUBLE_FREE;
        res_addr   <= '0;
        res_num    <= free_idx;
      end
      default: ;
    endcase
  end

  // Result ports.
  assign num_wide       = ADDR_W'(res_num);
  assign status         = res_status;
  assign block_address  = res_addr;
  assign block_number   = num_wide[5:0];
  assign num_free       = (eff_count > used_count) ? eff_count - used_count : '0;
  assign alloc_total    = alloc_cnt;
  assign fallback_total = fb_cnt;

endmodule

// File: sv/bba_map.sv
// ----------------------------------------------------------------------------
// bba_map
// One-bit-per-block used map: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bba_map #(
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/bba_div.sv
// ----------------------------------------------------------------------------
// bba_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bba_div
  import bba_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ADDR_W-1:0] dividend,
  input  logic [SIZE_W-1:0] divisor,
  output div_res_t          res
);

  localparam int CNT_W = $clog2(ADDR_W);
  localparam logic [CNT_W-1:0] LastStep = CNT_W'(ADDR_W - 1);

  logic              running;
  logic              done;
  logic [CNT_W-1:0]  step;
  logic [ADDR_W-1:0] quo;
  logic [SIZE_W-1:0] rem;
  logic [SIZE_W:0]   trial;
  logic              fits;
  logic [SIZE_W-1:0] rem_next;

  // One shift-and-subtract step.
  always_comb begin
    trial    = {rem, quo[ADDR_W-1]};
    fits     = trial >= {1'b0, divisor};
    rem_next = fits ? SIZE_W'(trial - {1'b0, divisor}) : trial[SIZE_W-1:0];
  end

  // Step counter and completion strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + 1'b1;
        if (step == LastStep) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (running) begin
      quo <= {quo[ADDR_W-2:0], fits};
      rem <= rem_next;
    end
  end

  assign res.done      = done;
  assign res.quotient  = quo;
  assign res.remainder = rem;

endmodule

// File: sv/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks of the bitmap block allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bba_checker
  import bba_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [1:0]         status,
  input logic [ADDR_W-1:0]  block_address,
  input logic [COUNT_W-1:0] num_free
);

  // A result only follows a cycle of work.
  `BBA_ASSERT_IMP(a_done_after_busy, clk, rst, done, $past(busy))

  // An accepted request makes the block busy.
  `BBA_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy)

  // One request gives one result strobe.
  `BBA_ASSERT_NXT(a_done_single, clk, rst, done, !done)

  // Exhaustion means no free block remains.
  `BBA_ASSERT_IMP(a_exhausted_empty, clk, rst, done && status == STATUS_EXHAUSTED, num_free == '0)

  // Only a successful transfer of an allocation carries an address.
  `BBA_ASSERT_IMP(a_addr_zero, clk, rst, done && status != STATUS_OK, block_address == '0)

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .status        (status),
  .block_address (block_address),
  .num_free      (num_free)
);
